@@ src/hiqp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hiqp_pkg: shared constants and types for the hash insert block
// Field widths, home-slot arithmetic constants, status codes and the queue
// status struct used by the front and back parts.
// ----------------------------------------------------------------------------
package hiqp_pkg;

   localparam int KEY_W           = 31;
   localparam int SLOT_W          = 10;
   localparam int PROBE_W         = 11;
   localparam int DEF_TABLE_SLOTS = 1024;

   // Home slot: key mod HOME_MOD through a reciprocal multiply and one correction.
   localparam int HOME_MOD     = 2017;
   localparam int MOD_W        = 11;
   localparam int RECIP1_SHIFT = 41;
   localparam logic [KEY_W-1:0] RECIP1 =
      KEY_W'((64'd1 << RECIP1_SHIFT) / 64'(HOME_MOD));
   localparam int PROD1_W      = 2 * KEY_W;
   localparam int QUO1_W       = PROD1_W - RECIP1_SHIFT;
   localparam int PROD2_W      = QUO1_W + MOD_W;

   // Second reduction: remainder mod the table size, same scheme.
   localparam int RECIP2_SHIFT = 22;
   localparam int RECIP2_W     = 22;
   localparam int PROD3_W      = MOD_W + RECIP2_W;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;

   localparam logic STATUS_INSERTED = 1'b0;
   localparam logic STATUS_FULL     = 1'b1;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage
`default_nettype wire

@@ src/hiqp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hiqp_if: request and response channel interfaces
// Valid/ready channels carrying the key in and the insert result out.
// ----------------------------------------------------------------------------
interface hiqp_req_if;
   logic                        valid;
   logic                        ready;
   logic [hiqp_pkg::KEY_W-1:0]  key;

   modport source (output valid, output key, input ready);
   modport sink   (input valid, input key, output ready);
endinterface

interface hiqp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hiqp_pkg::SLOT_W-1:0]  slot_index;
   logic [hiqp_pkg::PROBE_W-1:0] probe_count;
   logic                         status;

   modport source (output valid, output slot_index, output probe_count, output status,
                   input ready);
   modport sink   (input valid, input slot_index, input probe_count, input status,
                   output ready);
endinterface
`default_nettype wire

@@ src/hiqp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hiqp_front: home slot pipeline
// Four register stages compute (key mod 2017) mod TABLE_SLOTS with reciprocal
// multiplies and single corrections, then push key and home slot to the queue.
// ----------------------------------------------------------------------------
module hiqp_front #(
   parameter int TABLE_SLOTS = hiqp_pkg::DEF_TABLE_SLOTS,
   parameter int IDX_W       = 10,
   parameter int CNT_W       = 11
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [hiqp_pkg::KEY_W-1:0]  in_key,
   output logic                             in_ready,
   input  wire logic                        hold,
   input  wire hiqp_pkg::fifo_status_type   q_status,
   output logic                             push_valid,
   output logic [hiqp_pkg::KEY_W-1:0]       push_key,
   output logic [IDX_W-1:0]                 push_home
);

   localparam int KEY_W   = hiqp_pkg::KEY_W;
   localparam int PROD1_W = hiqp_pkg::PROD1_W;
   localparam int PROD2_W = hiqp_pkg::PROD2_W;
   localparam int MOD_W   = hiqp_pkg::MOD_W;
   localparam int PROD3_W = hiqp_pkg::PROD3_W;
   localparam int R2_W    = hiqp_pkg::RECIP2_W;
   localparam int SH1     = hiqp_pkg::RECIP1_SHIFT;
   localparam int SH2     = hiqp_pkg::RECIP2_SHIFT;
   localparam int P4_W    = MOD_W + CNT_W;
   localparam logic [R2_W-1:0] RECIP2 =
      R2_W'((64'd1 << SH2) / 64'(TABLE_SLOTS));

   logic                  adv;
   logic                  accept;

   logic                  s1_valid_ff, s1_valid_in;
   logic [KEY_W-1:0]      s1_key_ff;
   logic [PROD1_W-1:0]    s1_prod_ff, s1_prod_in;

   logic                  s2_valid_ff;
   logic [KEY_W-1:0]      s2_key_ff;
   logic [PROD2_W-1:0]    s2_prod_ff, s2_prod_in;

   logic                  s3_valid_ff;
   logic [KEY_W-1:0]      s3_key_ff;
   logic [MOD_W-1:0]      s3_rem_ff, s3_rem_in;
   logic [PROD3_W-1:0]    s3_prod_ff, s3_prod_in;
   logic [PROD2_W-1:0]    s2_diff;
   logic [MOD_W:0]        s2_rem_raw;

   logic                  s4_valid_ff;
   logic [KEY_W-1:0]      s4_key_ff;
   logic [MOD_W-1:0]      s4_rem_ff;
   logic [P4_W-1:0]       s4_prod_ff, s4_prod_in;
   logic [P4_W-1:0]       s4_diff;
   logic [P4_W-1:0]       s4_home;

   // The whole pipeline moves together unless the last stage cannot push.
   assign adv         = !s4_valid_ff || !q_status.full;
   assign in_ready    = adv && !hold;
   assign accept      = in_valid && in_ready;
   assign s1_valid_in = accept;

   assign s1_prod_in = PROD1_W'(in_key) * PROD1_W'(hiqp_pkg::RECIP1);
   assign s2_prod_in = PROD2_W'(s1_prod_ff[PROD1_W-1:SH1]) *
                       PROD2_W'(hiqp_pkg::HOME_MOD);

   // The quotient estimate is low by at most one, so one subtract fixes it.
   assign s2_diff    = PROD2_W'(s2_key_ff) - s2_prod_ff;
   assign s2_rem_raw = s2_diff[MOD_W:0];
   always_comb begin
      if (s2_rem_raw >= (MOD_W+1)'(hiqp_pkg::HOME_MOD)) begin
         s3_rem_in = MOD_W'(s2_rem_raw - (MOD_W+1)'(hiqp_pkg::HOME_MOD));
      end else begin
         s3_rem_in = MOD_W'(s2_rem_raw);
      end
   end
   assign s3_prod_in = PROD3_W'(s3_rem_in) * PROD3_W'(RECIP2);

   assign s4_prod_in = P4_W'(s3_prod_ff[PROD3_W-1:SH2]) * P4_W'(TABLE_SLOTS);

   assign s4_diff = P4_W'(s4_rem_ff) - s4_prod_ff;
   always_comb begin
      if (s4_diff >= P4_W'(TABLE_SLOTS)) begin
         s4_home = s4_diff - P4_W'(TABLE_SLOTS);
      end else begin
         s4_home = s4_diff;
      end
   end

   assign push_valid = s4_valid_ff && !q_status.full;
   assign push_key   = s4_key_ff;
   assign push_home  = IDX_W'(s4_home);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_key_ff  <= in_key;
         s1_prod_ff <= s1_prod_in;
         s2_key_ff  <= s1_key_ff;
         s2_prod_ff <= s2_prod_in;
         s3_key_ff  <= s2_key_ff;
         s3_rem_ff  <= s3_rem_in;
         s3_prod_ff <= s3_prod_in;
         s4_key_ff  <= s3_key_ff;
         s4_rem_ff  <= s3_rem_ff;
         s4_prod_ff <= s4_prod_in;
      end
   end

endmodule
`default_nettype wire

@@ src/hiqp_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hiqp_fifo: small queue between the front and back parts
// Holds key and home slot of items waiting for the probe engine.
// ----------------------------------------------------------------------------
module hiqp_fifo #(
   parameter int DATA_W = 41
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push_valid,
   input  wire logic [DATA_W-1:0]          push_data,
   input  wire logic                       pop,
   output logic [DATA_W-1:0]               pop_data,
   output hiqp_pkg::fifo_status_type       status
);

   localparam int AW    = hiqp_pkg::Q_AW;
   localparam int DEPTH = hiqp_pkg::Q_DEPTH;

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW:0]       count_ff, count_in;

   assign status.full  = (count_ff == (AW+1)'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ src/hiqp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hiqp_back: probe engine and slot tables
// Clears the occupancy table after reset, then takes one queued item at a
// time and walks the triangular probe sequence, one slot read per cycle.
// ----------------------------------------------------------------------------
module hiqp_back #(
   parameter int TABLE_SLOTS = hiqp_pkg::DEF_TABLE_SLOTS,
   parameter int IDX_W       = 10,
   parameter int CNT_W       = 11
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hiqp_pkg::fifo_status_type     q_status,
   input  wire logic [hiqp_pkg::KEY_W-1:0]    q_key,
   input  wire logic [IDX_W-1:0]              q_home,
   output logic                               q_pop,
   output logic                               clearing,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [hiqp_pkg::SLOT_W-1:0]        out_slot_index,
   output logic [hiqp_pkg::PROBE_W-1:0]       out_probe_count,
   output logic                               out_status
);

   localparam int KEY_W   = hiqp_pkg::KEY_W;
   localparam int SLOT_W  = hiqp_pkg::SLOT_W;
   localparam int PROBE_W = hiqp_pkg::PROBE_W;
   localparam logic [PROBE_W-1:0] FULL_PROBES = PROBE_W'(TABLE_SLOTS);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_PROBE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [IDX_W-1:0]   nxt_pos_ff, nxt_pos_in;
   logic [CNT_W-1:0]   nxt_probe_ff, nxt_probe_in;
   logic [IDX_W-1:0]   chk_pos_ff, chk_pos_in;
   logic [CNT_W-1:0]   chk_probe_ff, chk_probe_in;
   logic               chk_valid_ff, chk_valid_in;
   logic               used_rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [PROBE_W-1:0] rsp_probe_ff, rsp_probe_in;
   logic               rsp_status_ff, rsp_status_in;

   logic               slot_used_mem [TABLE_SLOTS];
   logic [KEY_W-1:0]   slot_key_mem  [TABLE_SLOTS];

   logic               found;
   logic               table_full;
   logic               rsp_free;
   logic [CNT_W:0]     pos_sum;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_free  = !rsp_valid_ff || out_ready;
   assign q_pop     = (state_ff == ST_IDLE) && !q_status.empty && rsp_free;
   assign found     = (state_ff == ST_PROBE) && chk_valid_ff && !used_rd_ff;
   assign table_full = (state_ff == ST_PROBE) && chk_valid_ff && used_rd_ff &&
                       (chk_probe_ff == CNT_W'(TABLE_SLOTS - 1));

   // Next probe position: pos + probe + 1 stays below twice the table size.
   assign pos_sum = (CNT_W+1)'(nxt_pos_ff) + (CNT_W+1)'(nxt_probe_ff) + (CNT_W+1)'(1);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      key_in        = key_ff;
      nxt_pos_in    = nxt_pos_ff;
      nxt_probe_in  = nxt_probe_ff;
      chk_pos_in    = chk_pos_ff;
      chk_probe_in  = chk_probe_ff;
      chk_valid_in  = chk_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !out_ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_probe_in  = rsp_probe_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + IDX_W'(1);
            if (clr_addr_ff == IDX_W'(TABLE_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_pop) begin
               key_in       = q_key;
               nxt_pos_in   = q_home;
               nxt_probe_in = '0;
               chk_valid_in = 1'b0;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (found) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = SLOT_W'(chk_pos_ff);
               rsp_probe_in  = PROBE_W'(chk_probe_ff);
               rsp_status_in = hiqp_pkg::STATUS_INSERTED;
               chk_valid_in  = 1'b0;
               state_in      = ST_IDLE;
            end else if (table_full) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = '0;
               rsp_probe_in  = FULL_PROBES;
               rsp_status_in = hiqp_pkg::STATUS_FULL;
               chk_valid_in  = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               // The read of nxt_pos goes out now; its data is checked next cycle.
               chk_pos_in   = nxt_pos_ff;
               chk_probe_in = nxt_probe_ff;
               chk_valid_in = 1'b1;
               nxt_probe_in = nxt_probe_ff + CNT_W'(1);
               if (pos_sum >= (CNT_W+1)'(TABLE_SLOTS)) begin
                  nxt_pos_in = IDX_W'(pos_sum - (CNT_W+1)'(TABLE_SLOTS));
               end else begin
                  nxt_pos_in = IDX_W'(pos_sum);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      nxt_pos_ff    <= nxt_pos_in;
      nxt_probe_ff  <= nxt_probe_in;
      chk_pos_ff    <= chk_pos_in;
      chk_probe_ff  <= chk_probe_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_probe_ff  <= rsp_probe_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign mem_we    = clearing || found;
   assign mem_waddr = clearing ? clr_addr_ff : chk_pos_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_used_mem[mem_waddr] <= !clearing;
      end
      used_rd_ff <= slot_used_mem[nxt_pos_ff];
   end

   always_ff @(posedge clock) begin
      if (found) begin
         slot_key_mem[chk_pos_ff] <= key_ff;
      end
   end

   assign out_valid       = rsp_valid_ff;
   assign out_slot_index  = rsp_slot_ff;
   assign out_probe_count = rsp_probe_ff;
   assign out_status      = rsp_status_ff;

endmodule
`default_nettype wire

@@ src/hash_insert_quadratic_probe_top.sv @@
// The probe engine takes one queued key at a time, one slot read per cycle; a
// 4-entry queue lets the front take keys ahead meanwhile. After reset a clearing
// pass empties the occupancy table, with req ready held low until it ends.
`default_nettype none
// ----------------------------------------------------------------------------
// hash_insert_quadratic_probe_top: open-addressed hash table insert
// Home slot pipeline, queue and triangular probe engine behind valid/ready
// request and response channels.
// ----------------------------------------------------------------------------
module hash_insert_quadratic_probe_top #(
   parameter int TABLE_SLOTS = hiqp_pkg::DEF_TABLE_SLOTS
) (
   input  wire logic   clock,
   input  wire logic   reset,
   hiqp_req_if.sink    req_chan,
   hiqp_rsp_if.source  rsp_chan
);

   localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
   localparam int KEY_W  = hiqp_pkg::KEY_W;
   localparam int DATA_W = KEY_W + IDX_W;

   hiqp_pkg::fifo_status_type q_status;
   logic                      push_valid;
   logic [KEY_W-1:0]          push_key;
   logic [IDX_W-1:0]          push_home;
   logic [DATA_W-1:0]         pop_data;
   logic                      q_pop;
   logic                      clearing;

   hiqp_front #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_key     (req_chan.key),
      .in_ready   (req_chan.ready),
      .hold       (clearing),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_key   (push_key),
      .push_home  (push_home)
   );

   hiqp_fifo #(
      .DATA_W (DATA_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_key, push_home}),
      .pop        (q_pop),
      .pop_data   (pop_data),
      .status     (q_status)
   );

   hiqp_back #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_key           (pop_data[DATA_W-1:IDX_W]),
      .q_home          (pop_data[IDX_W-1:0]),
      .q_pop           (q_pop),
      .clearing        (clearing),
      .out_valid       (rsp_chan.valid),
      .out_ready       (rsp_chan.ready),
      .out_slot_index  (rsp_chan.slot_index),
      .out_probe_count (rsp_chan.probe_count),
      .out_status      (rsp_chan.status)
   );

endmodule
`default_nettype wire

@@ verif/tb_hash_insert_quadratic_probe_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_insert_quadratic_probe_top: testbench for the hash insert block
// Sends keys through the request channel and tracks slot occupancy in a
// scoreboard. The scoreboard predicts the slot, probe count and status of
// every insert, up to and past the point where the table is full. Both
// channels idle at random, the response side stalls long enough to back up
// the input, and the sender drains the block between phases.
// ----------------------------------------------------------------------------
module tb_hash_insert_quadratic_probe_top;

   localparam int KEY_W       = hiqp_pkg::KEY_W;
   localparam int SLOT_W      = hiqp_pkg::SLOT_W;
   localparam int PROBE_W     = hiqp_pkg::PROBE_W;
   localparam int TABLE_SLOTS = hiqp_pkg::DEF_TABLE_SLOTS;
   localparam int RANDOM_KEYS = 1031;
   localparam int CYCLE_LIMIT = 6_000_000;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot_index;
      logic [PROBE_W-1:0] probe_count;
      logic               status;
   } placement_type;

   // Occupancy tracker: predicts where each key lands and checks the results.
   class slot_table_model;
      bit            slot_used[];
      int unsigned   table_slots;
      placement_type due_placements[$];
      int            mismatches;

      function new(int unsigned slots);
         table_slots = slots;
         slot_used   = new[slots];
         mismatches  = 0;
      endfunction

      function void note_key(logic [KEY_W-1:0] key);
         placement_type want;
         int unsigned   key_val;
         int unsigned   pos;
         int unsigned   probe;
         want.slot_index  = '0;
         want.probe_count = PROBE_W'(table_slots);
         want.status      = hiqp_pkg::STATUS_FULL;
         key_val = key;
         pos = (key_val % hiqp_pkg::HOME_MOD) % table_slots;
         for (probe = 0; probe < table_slots; probe++) begin
            if (!slot_used[pos]) begin
               slot_used[pos]   = 1'b1;
               want.slot_index  = SLOT_W'(pos);
               want.probe_count = PROBE_W'(probe);
               want.status      = hiqp_pkg::STATUS_INSERTED;
               break;
            end
            // Triangular step: offsets 0, 1, 3, 6, ... from the home slot.
            pos = (pos + probe + 1) % table_slots;
         end
         due_placements.push_back(want);
      endfunction

      function void check_placement(logic [SLOT_W-1:0] slot_index,
                                    logic [PROBE_W-1:0] probe_count, logic status);
         placement_type want;
         if (due_placements.size() == 0) begin
            $error("unexpected item: slot_index %0d probe_count %0d status %0d",
                   slot_index, probe_count, status);
            mismatches++;
            return;
         end
         want = due_placements.pop_front();
         if (slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, actual %0d", want.slot_index, slot_index);
            mismatches++;
         end
         if (probe_count !== want.probe_count) begin
            $error("probe_count: expected %0d, actual %0d", want.probe_count, probe_count);
            mismatches++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
      endfunction

      function int pending();
         return due_placements.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   hiqp_req_if req_if ();
   hiqp_rsp_if rsp_if ();

   hash_insert_quadratic_probe_top #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   slot_table_model  slots_model;
   logic [KEY_W-1:0] keys_offered[$];
   int               keys_accepted = 0;
   int               cycle_count   = 0;
   bit               no_idle       = 1'b0;

   // Home slot 0 repeated, wrap-around from slot 1023, keys colliding through
   // both reductions, and the extremes of the key field.
   logic [KEY_W-1:0] directed_keys [19] = '{
      31'd0, 31'd0, 31'd0, 31'd2017, 31'd3041, 31'd1024,
      31'd1023, 31'd1023, 31'd1023, 31'd2016, 31'd4033, 31'd2018,
      31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFE, 31'h4000_0000,
      31'h5555_5555, 31'h2AAA_AAAA, 31'd1
   };

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL hash_insert_quadratic_probe_top");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         slots_model.note_key(req_if.key);
         keys_accepted <= keys_accepted + 1;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         slots_model.check_placement(rsp_if.slot_index, rsp_if.probe_count, rsp_if.status);
      end
   end

   task automatic send_key(input logic [KEY_W-1:0] key);
      while (!no_idle && $urandom_range(0, 99) < 12) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.key   <= key;
      keys_offered.push_back(key);
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (slots_model.pending() > 0) @(posedge clock);
   endtask

   initial begin : rsp_side
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         // One long hold-off fills the queue and stalls the request side.
         if (!hold_done && keys_accepted >= 300) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (no_idle) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= 12);
         end
      end
   end

   initial begin : req_side
      logic [KEY_W-1:0] key;
      int               pick;
      slots_model  = new(TABLE_SLOTS);
      req_if.valid = 1'b0;
      req_if.key   = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_keys[i]) send_key(directed_keys[i]);
      wait_drained();

      // Past about 1024 inserts the table is full and every key is dropped.
      for (int n = 0; n < RANDOM_KEYS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            key = KEY_W'($urandom);
         end else if (pick < 60) begin
            key = KEY_W'($urandom_range(0, 4095));
         end else if (pick < 75) begin
            key = KEY_W'(hiqp_pkg::HOME_MOD * $urandom_range(0, 1064000) +
                         $urandom_range(0, 3));
         end else if (pick < 90) begin
            key = keys_offered[$urandom_range(0, keys_offered.size() - 1)];
         end else begin
            key = KEY_W'(31'h7FFF_FFFF - $urandom_range(0, 2047));
         end
         if (n == 700) wait_drained();
         no_idle = (n >= 400 && n < 600);
         send_key(key);
      end
      no_idle = 1'b0;

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (slots_model.pending() > 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (slots_model.mismatches == 0 && slots_model.pending() == 0) begin
         $display("PASS hash_insert_quadratic_probe_top");
      end else begin
         $display("FAIL hash_insert_quadratic_probe_top");
      end
      $finish;
   end

endmodule
